// ===== design/volume_control_point_macros.svh =====
// assertion macros for the volume control point checker
`ifndef VOLUME_CONTROL_POINT_MACROS_SVH
`define VOLUME_CONTROL_POINT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define VCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vcp_pkg.sv =====
// types, codes and widths shared by the volume control point files
package vcp_pkg;

  localparam int unsigned VOL_W      = 8;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned KIND_W     = 8;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [VOL_W-1:0] VOL_MAX    = 8'd255;
  localparam logic [VOL_W-1:0] STEP_RESET = 8'd1;

  localparam logic [KIND_W-1:0] OP_DOWN        = 8'd0;
  localparam logic [KIND_W-1:0] OP_UP          = 8'd1;
  localparam logic [KIND_W-1:0] OP_UNMUTE_DOWN = 8'd2;
  localparam logic [KIND_W-1:0] OP_UNMUTE_UP   = 8'd3;
  localparam logic [KIND_W-1:0] OP_SET         = 8'd4;
  localparam logic [KIND_W-1:0] OP_UNMUTE      = 8'd5;
  localparam logic [KIND_W-1:0] OP_MUTE        = 8'd6;

  localparam logic [LEN_W-1:0] LEN_SET   = 9'd3;
  localparam logic [LEN_W-1:0] LEN_OTHER = 9'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OFFSET  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LENGTH  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OPCODE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNTER = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MUTE   = 2'd2;

  // first field in the highest bits
  typedef struct packed {
    logic [LEN_W-1:0] write_offset;
    logic [LEN_W-1:0] write_length;
    logic [VOL_W-1:0] new_volume;
    logic [CNT_W-1:0] counter;
  } in_data_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    in_data_t          data;
  } item_t;

  typedef struct packed {
    logic             volume_flag;
    logic             flag_notify;
    logic             state_notify;
    logic [CNT_W-1:0] change_count;
    logic             mute_state;
    logic [VOL_W-1:0] volume_level;
  } out_data_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    out_data_t           data;
  } result_t;

  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic             mute;
    logic [CNT_W-1:0] change_count;
    logic             flag;
  } vcp_state_t;

endpackage

// ===== design/volume_control_point.sv =====
// volume control point top level: input stage, evaluation, state and result register
// One control point write per cycle is taken in sustained flow while the result side
// does not stall. A transfer on the input side lands in an input register; the checks
// and the opcode then run on that register against the stored volume, mute, change
// counter and flag, which update on the same edge that loads the result register, so
// back-to-back writes each see the state left by the one before. Stalls on the result side
// hold the result register and then the input register. Configuration writes load the
// step, volume or mute unless the result register loads, and belong in idle time.
module volume_control_point (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // counter, new_volume, write_length, write_offset, zero fill
  input  logic [vcp_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [vcp_pkg::KIND_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // volume_level, mute_state, change_count, state_notify, flag_notify, volume_flag,
  // zero fill
  output logic [vcp_pkg::OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [vcp_pkg::STATUS_W-1:0]   out_tuser,
  input  logic                           cfg_we,
  input  logic [vcp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vcp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vcp_pkg::*;

  localparam int unsigned IN_PAD  = IN_DATA_W - $bits(in_data_t);
  localparam int unsigned OUT_PAD = OUT_DATA_W - $bits(out_data_t);

  item_t            item_r;
  logic             item_valid_r;
  result_t          result_r;
  logic             out_valid_r;
  vcp_state_t       state_r;
  logic [VOL_W-1:0] step_r;

  result_t          result_nxt;
  vcp_state_t       state_nxt;
  logic             out_load;
  logic             in_xfer;

  assign out_load  = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || out_load;
  assign in_xfer   = in_tvalid && in_tready;

  vcp_eval u_eval (
    .item   (item_r),
    .cur    (state_r),
    .step   (step_r),
    .result (result_nxt),
    .nxt    (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.kind <= in_tuser;
      item_r.data <= in_tdata[$bits(in_data_t)-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      step_r  <= STEP_RESET;
    end else if (out_load) begin
      state_r <= state_nxt;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME_STEP: begin
          if (cfg_wdata != '0) begin
            step_r <= cfg_wdata[VOL_W-1:0];
          end
        end
        REG_INITIAL_VOLUME: state_r.volume <= cfg_wdata[VOL_W-1:0];
        REG_INITIAL_MUTE:   state_r.mute   <= cfg_wdata[0];
        default:            ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, result_r.data};
  assign out_tuser  = result_r.status;

  // upper input fill bits are not used
  logic unused_pad;
  assign unused_pad = ^{1'b0, in_tdata[IN_DATA_W-1:IN_DATA_W-IN_PAD]};

endmodule

// ===== design/vcp_eval.sv =====
// control point write checks and opcode application
module vcp_eval (
  input  vcp_pkg::item_t              item,
  input  vcp_pkg::vcp_state_t         cur,
  input  logic [vcp_pkg::VOL_W-1:0]   step,
  output vcp_pkg::result_t            result,
  output vcp_pkg::vcp_state_t         nxt
);
  import vcp_pkg::*;

  logic [LEN_W-1:0]    want_len;
  logic [STATUS_W-1:0] status;
  logic [VOL_W:0]      up_sum;
  logic [VOL_W-1:0]    vol_down;
  logic [VOL_W-1:0]    vol_up;
  logic [VOL_W-1:0]    vol_new;
  logic                mute_new;
  logic                changed;
  logic                vol_op;
  logic                flag_set;

  assign want_len = (item.kind == OP_SET) ? LEN_SET : LEN_OTHER;

  always_comb begin
    if (item.data.write_offset != '0) begin
      status = ST_OFFSET;
    end else if (item.data.write_length == '0) begin
      status = ST_LENGTH;
    end else if (item.kind > OP_MUTE) begin
      status = ST_OPCODE;
    end else if (item.data.write_length != want_len) begin
      status = ST_LENGTH;
    end else if (item.data.counter != cur.change_count) begin
      status = ST_COUNTER;
    end else begin
      status = ST_OK;
    end
  end

  // saturating step
  assign up_sum   = {1'b0, cur.volume} + {1'b0, step};
  assign vol_up   = up_sum[VOL_W] ? VOL_MAX : up_sum[VOL_W-1:0];
  assign vol_down = (cur.volume > step) ? (cur.volume - step) : '0;

  always_comb begin
    vol_new  = cur.volume;
    mute_new = cur.mute;
    case (item.kind)
      OP_DOWN:        vol_new = vol_down;
      OP_UP:          vol_new = vol_up;
      OP_UNMUTE_DOWN: begin
        vol_new  = vol_down;
        mute_new = 1'b0;
      end
      OP_UNMUTE_UP:   begin
        vol_new  = vol_up;
        mute_new = 1'b0;
      end
      OP_SET:         vol_new = item.data.new_volume;
      OP_UNMUTE:      mute_new = 1'b0;
      OP_MUTE:        mute_new = 1'b1;
      default:        ;
    endcase
  end

  assign vol_op   = (status == ST_OK) && (item.kind <= OP_SET);
  assign changed  = (status == ST_OK) && ((vol_new != cur.volume) || (mute_new != cur.mute));
  assign flag_set = vol_op && !cur.flag;

  always_comb begin
    nxt = cur;
    if (status == ST_OK) begin
      nxt.volume = vol_new;
      nxt.mute   = mute_new;
    end
    if (changed) begin
      nxt.change_count = cur.change_count + 1'b1;
    end
    if (flag_set) begin
      nxt.flag = 1'b1;
    end
  end

  always_comb begin
    result.status            = status;
    result.data.volume_level = nxt.volume;
    result.data.mute_state   = nxt.mute;
    result.data.change_count = nxt.change_count;
    result.data.state_notify = changed;
    result.data.flag_notify  = flag_set;
    result.data.volume_flag  = nxt.flag;
  end

endmodule

// ===== design/vcp_checker.sv =====
// port-level checks for the volume control point, bound to the top level
`include "volume_control_point_macros.svh"

module vcp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [vcp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [vcp_pkg::STATUS_W-1:0]   out_tuser
);
  import vcp_pkg::*;

  out_data_t od;
  assign od = out_tdata[$bits(out_data_t)-1:0];

  `VCP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  `VCP_ASSERT_NOW(a_reject_quiet, out_tvalid && (out_tuser != ST_OK),
    !od.state_notify && !od.flag_notify, "rejected write raised a notify")

  `VCP_ASSERT_NOW(a_flag_sticky, out_tvalid && od.flag_notify,
    od.volume_flag, "flag notify without flag set")

  `VCP_ASSERT_NOW(a_status_range, out_tvalid,
    out_tuser <= ST_COUNTER, "status code out of range")

endmodule

bind volume_control_point vcp_checker u_vcp_checker (.*);
